// ----- hdl/pal_pkg.sv -----
// Shared types and fixed widths for the positional array list.
package pal_pkg;

  // Width of one list element and of the request code.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACT_W  = 3;

  // Fixed part of a queued command: opcode, failure flag and element value.
  localparam int unsigned CMD_FIXED_W = ACT_W + 1 + DATA_W;

  // Request codes. Codes five to seven are unused and always fail.
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

endpackage

// ----- hdl/pal_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pal_cmd_fifo.sv -----
// Two-entry command queue between the front and back parts.
module pal_cmd_fifo #(
  parameter int unsigned WIDTH = 57
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/pal_front.sv -----
// Front part: accepts requests, tracks the list length and decides failures up front.
module pal_front import pal_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 64,
  parameter int unsigned POS_W = 7,
  localparam int unsigned CMD_W = CMD_FIXED_W + 3 * POS_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output logic [CMD_W-1:0]         q_cmd_o
);

  typedef struct packed {
    action_e           op;
    logic              fail;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  len_before;
    logic [POS_W-1:0]  len_after;
    logic [DATA_W-1:0] value;
  } cmd_t;

  localparam logic [POS_W-1:0] ONE     = POS_W'(1);
  localparam logic [POS_W-1:0] DEPTH_C = POS_W'(LIST_DEPTH);

  logic [POS_W-1:0] count_q, count_d;
  cmd_t             cmd;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;
  assign q_cmd_o    = cmd;

  always_comb begin
    cmd.op         = action_e'(action_i);
    cmd.fail       = 1'b1;
    cmd.pos        = position_i;
    cmd.len_before = count_q;
    cmd.len_after  = count_q;
    cmd.value      = $unsigned(value_i);
    case (cmd.op)
      ACT_INSERT: begin
        if (count_q != DEPTH_C && position_i != '0 && (position_i - ONE) <= count_q) begin
          cmd.fail      = 1'b0;
          cmd.len_after = count_q + ONE;
        end
      end
      ACT_DELETE: begin
        if (position_i != '0 && position_i <= count_q) begin
          cmd.fail      = 1'b0;
          cmd.len_after = count_q - ONE;
        end
      end
      ACT_GET: begin
        if (position_i != '0 && position_i <= count_q) begin
          cmd.fail = 1'b0;
        end
      end
      ACT_LOCATE: begin
        // The back part settles the outcome of a search over a non-empty list.
        cmd.fail = (count_q == '0);
      end
      ACT_CLEAR: begin
        cmd.fail      = 1'b0;
        cmd.len_after = '0;
      end
      default: begin
        cmd.fail = 1'b1;
      end
    endcase
  end

  assign count_d = q_push_o ? cmd.len_after : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ----- hdl/pal_back.sv -----
// Back part: carries out commands on the element RAM and holds the result register.
module pal_back import pal_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 64,
  parameter int unsigned POS_W = 7,
  localparam int unsigned CMD_W = CMD_FIXED_W + 3 * POS_W,
  localparam int unsigned AW = $clog2(LIST_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  logic [CMD_W-1:0]         cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [POS_W-1:0]         found_position_o,
  output logic [POS_W-1:0]         list_length_o
);

  typedef struct packed {
    action_e           op;
    logic              fail;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  len_before;
    logic [POS_W-1:0]  len_after;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_GET  = 7'b0000010,
    ST_DEL  = 7'b0000100,
    ST_INS  = 7'b0001000,
    ST_INSV = 7'b0010000,
    ST_SCAN = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  localparam logic [POS_W-1:0] ONE = POS_W'(1);
  localparam logic [POS_W-1:0] TWO = POS_W'(2);

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d, cmd_in;
  logic [POS_W-1:0]  ptr_q, ptr_d;
  logic              first_q, first_d;
  logic              res_fail_q, res_fail_d;
  logic [DATA_W-1:0] res_rd_q, res_rd_d;
  logic [POS_W-1:0]  res_found_q, res_found_d;

  logic              out_valid_q, out_valid_d;
  logic              out_status_q, out_status_d;
  logic [DATA_W-1:0] out_rd_q, out_rd_d;
  logic [POS_W-1:0]  out_found_q, out_found_d;
  logic [POS_W-1:0]  out_len_q, out_len_d;

  logic              ram_re, ram_we;
  logic [POS_W-1:0]  ram_raddr, ram_waddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign cmd_in = cmd_t'(cmd_i);

  pal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    ptr_d        = ptr_q;
    first_d      = first_q;
    res_fail_d   = res_fail_q;
    res_rd_d     = res_rd_q;
    res_found_d  = res_found_q;
    cmd_pop_o    = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = ram_rdata;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_rd_d     = out_rd_q;
    out_found_d  = out_found_q;
    out_len_d    = out_len_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o   = 1'b1;
          cmd_d       = cmd_in;
          res_fail_d  = cmd_in.fail;
          res_rd_d    = '0;
          res_found_d = '0;
          first_d     = 1'b1;
          if (cmd_in.fail) begin
            state_d = ST_DONE;
          end else begin
            case (cmd_in.op)
              ACT_GET: begin
                ram_re    = 1'b1;
                ram_raddr = cmd_in.pos - ONE;
                state_d   = ST_GET;
              end
              ACT_DELETE: begin
                ram_re    = 1'b1;
                ram_raddr = cmd_in.pos - ONE;
                ptr_d     = cmd_in.pos;
                state_d   = ST_DEL;
              end
              ACT_INSERT: begin
                if ((cmd_in.pos - ONE) == cmd_in.len_before) begin
                  state_d = ST_INSV;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = cmd_in.len_before - ONE;
                  ptr_d     = cmd_in.len_before - ONE;
                  state_d   = ST_INS;
                end
              end
              ACT_LOCATE: begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                ptr_d      = ONE;
                res_fail_d = 1'b1;
                state_d    = ST_SCAN;
              end
              default: begin
                state_d = ST_DONE;
              end
            endcase
          end
        end
      end
      ST_GET: begin
        res_rd_d = ram_rdata;
        state_d  = ST_DONE;
      end
      ST_DEL: begin
        // The first word back is the removed entry; later words move down by one.
        if (first_q) begin
          res_rd_d = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q - TWO;
        end
        first_d = 1'b0;
        if (ptr_q < cmd_q.len_before) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q;
          ptr_d     = ptr_q + ONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_INS: begin
        // Move entries up from the tail toward the insert position.
        ram_we    = 1'b1;
        ram_waddr = ptr_q + ONE;
        if (ptr_q == (cmd_q.pos - ONE)) begin
          state_d = ST_INSV;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q - ONE;
          ptr_d     = ptr_q - ONE;
        end
      end
      ST_INSV: begin
        ram_we    = 1'b1;
        ram_waddr = cmd_q.pos - ONE;
        ram_wdata = cmd_q.value;
        state_d   = ST_DONE;
      end
      ST_SCAN: begin
        if (ram_rdata == cmd_q.value) begin
          res_found_d = ptr_q;
          res_fail_d  = 1'b0;
          state_d     = ST_DONE;
        end else if (ptr_q == cmd_q.len_before) begin
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q;
          ptr_d     = ptr_q + ONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_fail_q;
          out_rd_d     = res_rd_q;
          out_found_d  = res_found_q;
          out_len_d    = cmd_q.len_after;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ptr_q        <= ptr_d;
    first_q      <= first_d;
    res_fail_q   <= res_fail_d;
    res_rd_q     <= res_rd_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_rd_q     <= out_rd_d;
    out_found_q  <= out_found_d;
    out_len_q    <= out_len_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign read_value_o     = $signed(out_rd_q);
  assign found_position_o = out_found_q;
  assign list_length_o    = out_len_q;

endmodule

// ----- hdl/positional_array_list.sv -----
// Top level of the positional array list: front part, command queue and back part.
//
//   Channel   Direction  Handshake               Payload
//   request   in         in_valid_i/in_ready_o   action_i, position_i, value_i
//   result    out        out_valid_o/out_ready_i status_o, read_value_o,
//                                                found_position_o, list_length_o
//
// The front part takes a request whenever the two-entry command queue has
// room, so requests are taken while earlier ones are still at work.
// The back part runs one command at a time against a RAM with one write and one
// registered read port. Insert moves entries up from the tail, then writes the
// value; delete reads the removed entry and moves later ones down; locate scans
// from the head to the first match or the end. The shift and the search move one
// entry per cycle through the RAM port pair, which sets the sustained rate.
// Reset empties the list at once; no clearing pass runs over the RAM.
// A stalled result waits in the output register while the queue keeps filling.
module positional_array_list import pal_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 64,
  localparam int unsigned POS_W = $clog2(LIST_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [POS_W-1:0]         found_position_o,
  output logic [POS_W-1:0]         list_length_o
);

  localparam int unsigned CMD_W = CMD_FIXED_W + 3 * POS_W;

  logic             q_push, q_full, q_pop, q_valid;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  // Front part: classifies each transaction and keeps the running length.
  pal_front #(
    .LIST_DEPTH (LIST_DEPTH),
    .POS_W      (POS_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .position_i (position_i),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wdata)
  );

  // Queue of decoded commands; lets either side stall without the other.
  pal_cmd_fifo #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // Back part: element storage, shifting, search and the result register.
  pal_back #(
    .LIST_DEPTH (LIST_DEPTH),
    .POS_W      (POS_W)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (q_rdata),
    .cmd_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_position_o (found_position_o),
    .list_length_o    (list_length_o)
  );

endmodule

// ----- hdl/pal_checker.sv -----
// Port-level assertions for the positional array list, bound to the top level.
module pal_checker import pal_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 64,
  localparam int unsigned POS_W = $clog2(LIST_DEPTH + 1)
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     status_o,
  input logic signed [DATA_W-1:0] read_value_o,
  input logic [POS_W-1:0]         found_position_o,
  input logic [POS_W-1:0]         list_length_o
);

  // A result transaction stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // The reported length never exceeds the list capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> list_length_o <= POS_W'(LIST_DEPTH))
    else $error("list length above capacity");

  // A failed request carries neither a read value nor a match position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> read_value_o == '0 && found_position_o == '0)
    else $error("failure result with nonzero data");

  // A match position is a success and lies inside the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_position_o != '0 |->
      !status_o && found_position_o <= list_length_o && read_value_o == '0)
    else $error("match position inconsistent with result");

endmodule

bind positional_array_list pal_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_pal_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .read_value_o     (read_value_o),
  .found_position_o (found_position_o),
  .list_length_o    (list_length_o)
);

// ----- tb/sv/positional_array_list_test.sv -----
// Self-checking testbench for the positional array list: directed and random requests.
module positional_array_list_test import pal_pkg::*;;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned POS_W      = $clog2(LIST_DEPTH + 1);

  // The watchdog ends the run after this many cycles without any transaction.
  // The longest quiet stretch is the receiver hold-off in the back-pressure test.
  localparam int unsigned QUIET_LIMIT  = 4000;
  // Cycles left to run after the last result, to catch any extra results.
  localparam int unsigned SETTLE_CYCLES = 150;
  // Only the first mismatches are printed; all of them are counted.
  localparam int unsigned PRINT_LIMIT  = 40;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;
  } list_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [ACT_W-1:0]         action_i;
  logic [POS_W-1:0]         position_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     status_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [POS_W-1:0]         found_position_o;
  logic [POS_W-1:0]         list_length_o;

  // Our own copy of the list, advanced once per accepted request.
  logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH];
  int unsigned              shadow_len;

  // Results still owed by the block, oldest first.
  list_result_t pending_results [$];

  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // A small set of values that keeps locate requests finding matches, and
  // duplicates in the list so that the first match is the one reported.
  logic signed [DATA_W-1:0] value_pool [8] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1,
    32'sd5, 32'sd17, -32'sd300, 32'sh1234_5678
  };

  positional_array_list #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .found_position_o(found_position_o),
    .list_length_o   (list_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Computes the result of one request and updates the shadow list. Every
  // failure leaves the list as it was; clear only drops the length.
  function automatic list_result_t apply_request(logic [ACT_W-1:0] act,
                                                 logic [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] val);
    list_result_t res;
    int unsigned  p;
    res = '{status: 1'b1, read_value: '0, found_position: '0, list_length: '0};
    p = pos;
    case (act)
      ACT_INSERT: begin
        if (shadow_len < LIST_DEPTH && p >= 1 && p <= shadow_len + 1) begin
          for (int unsigned k = shadow_len; k >= p; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = val;
          shadow_len++;
          res.status = 1'b0;
        end
      end
      ACT_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          res.read_value = shadow_list[p-1];
          for (int unsigned k = p; k < shadow_len; k++) shadow_list[k-1] = shadow_list[k];
          shadow_len--;
          res.status = 1'b0;
        end
      end
      ACT_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          res.read_value = shadow_list[p-1];
          res.status = 1'b0;
        end
      end
      ACT_LOCATE: begin
        for (int unsigned k = 0; k < shadow_len; k++) begin
          if (res.status && shadow_list[k] == val) begin
            res.found_position = POS_W'(k + 1);
            res.status = 1'b0;
          end
        end
      end
      ACT_CLEAR: begin
        shadow_len = 0;
        res.status = 1'b0;
      end
      default: ;
    endcase
    res.list_length = POS_W'(shadow_len);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Offers one request and returns at the edge where it is accepted. The
  // expectation is recorded at that edge, so the shadow list always matches
  // the order in which the block takes requests.
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_request(act, pos, val));
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 60) return value_pool[$urandom_range(7)];
    return $signed($urandom());
  endfunction

  // Position that is valid for the current length most of the time, and any
  // 7-bit value otherwise so that out-of-range and high-bit cases occur.
  function automatic logic [POS_W-1:0] pick_position(int unsigned upper);
    if ($urandom_range(99) < 85 && upper >= 1) return POS_W'($urandom_range(upper, 1));
    return POS_W'($urandom_range((1 << POS_W) - 1));
  endfunction

  // Random mix weighted toward insert, so the list regularly runs full and
  // shifts and searches cover long lists; clear and unused codes are rare.
  task automatic send_random_request();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 42)      send_request(ACT_INSERT, pick_position(shadow_len + 1), pick_value());
    else if (roll < 62) send_request(ACT_DELETE, pick_position(shadow_len), pick_value());
    else if (roll < 78) send_request(ACT_GET, pick_position(shadow_len), pick_value());
    else if (roll < 95) send_request(ACT_LOCATE, pick_position(shadow_len), pick_value());
    else if (roll < 97) send_request(ACT_CLEAR, pick_position(shadow_len), pick_value());
    else send_request(ACT_W'($urandom_range(7, 5)), pick_position(shadow_len), pick_value());
  endtask

  // Edge cases on a short list: empty-list failures, bad positions, the
  // extremes of the value range, unused action codes and clear.
  task automatic test_directed();
    send_request(ACT_GET, 1, 0);
    send_request(ACT_DELETE, 1, 0);
    send_request(ACT_LOCATE, 0, 32'sd5);
    send_request(ACT_INSERT, 0, 32'sd9);
    send_request(ACT_INSERT, 2, 32'sd9);
    send_request(ACT_INSERT, 1, 32'sh8000_0000);
    send_request(ACT_INSERT, 2, 32'sh7fff_ffff);
    send_request(ACT_INSERT, 1, 32'sd0);
    send_request(ACT_INSERT, 3, -32'sd1);
    send_request(ACT_INSERT, 7'h7f, 32'sd1);
    send_request(ACT_GET, 1, 0);
    send_request(ACT_GET, 4, 0);
    send_request(ACT_GET, 5, 0);
    send_request(ACT_GET, 0, 0);
    send_request(ACT_LOCATE, 7'h7f, 32'sh7fff_ffff);
    send_request(ACT_LOCATE, 2, 32'sd12345);
    send_request(ACT_DELETE, 2, 0);
    send_request(ACT_DELETE, 0, 0);
    send_request(ACT_DELETE, 4, 0);
    send_request(3'd5, 1, 32'sd1);
    send_request(3'd6, 1, 32'sd1);
    send_request(3'd7, 1, 32'sd1);
    send_request(ACT_CLEAR, 3, 32'sd7);
    send_request(ACT_GET, 1, 0);
    send_request(ACT_LOCATE, 1, 32'sd0);
  endtask

  // Fills the list to capacity at random positions, then checks the full-list
  // refusal and both ends of a full list.
  task automatic test_full_list();
    send_request(ACT_CLEAR, 0, 0);
    while (shadow_len < LIST_DEPTH)
      send_request(ACT_INSERT, POS_W'($urandom_range(shadow_len + 1, 1)), pick_value());
    send_request(ACT_INSERT, 1, 32'sd1);
    send_request(ACT_INSERT, POS_W'(LIST_DEPTH + 1), 32'sd1);
    send_request(ACT_GET, POS_W'(LIST_DEPTH), 0);
    send_request(ACT_LOCATE, 0, shadow_list[LIST_DEPTH-1]);
    send_request(ACT_DELETE, POS_W'(LIST_DEPTH), 0);
    send_request(ACT_DELETE, 1, 0);
    send_request(ACT_INSERT, POS_W'(LIST_DEPTH - 1), 32'sh8000_0000);
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_random_request();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the command queue and output register fill and the input side stalls.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 400;
    repeat (40) send_random_request();
  endtask

  // Receiver side: random stalls, plus a long hold-off counted here.
  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Every accepted result is compared field by field with the oldest
  // expectation. Outputs are sampled at the edge, before the block updates.
  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no request outstanding");
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status)
          report_mismatch($sformatf("status %0b, expected %0b", status_o, exp_res.status));
        if (read_value_o !== exp_res.read_value)
          report_mismatch($sformatf("read_value %0d, expected %0d",
                                    read_value_o, exp_res.read_value));
        if (found_position_o !== exp_res.found_position)
          report_mismatch($sformatf("found_position %0d, expected %0d",
                                    found_position_o, exp_res.found_position));
        if (list_length_o !== exp_res.list_length)
          report_mismatch($sformatf("list_length %0d, expected %0d",
                                    list_length_o, exp_res.list_length));
      end
    end
  end

  // Watchdog: a hung block shows up as a long run of cycles with no
  // transaction on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    action_i           = '0;
    position_i         = '0;
    value_i            = '0;
    out_ready_i        = 1'b0;
    mismatch_count     = 0;
    quiet_cycles       = 0;
    hold_request       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    shadow_len         = 0;
    foreach (shadow_list[i]) shadow_list[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_list();
    test_random_traffic(430, 0, 0);
    test_random_traffic(430, 49, 0);
    test_backpressure();
    test_random_traffic(430, 0, 49);
    test_random_traffic(430, 9, 9);

    in_valid_i <= 1'b0;
    // The watchdog bounds this wait if results stop arriving.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
